### src/rtsp_pkg.sv
`timescale 1ns / 1ps

package rtsp_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 16384;
    localparam int DIST_BITS_DEF = 24;

    localparam int OP_W       = 2;
    localparam int FIELD_W    = 10;
    localparam int NC_W       = 11;
    localparam int OUT_W      = 24;
    localparam int EDGE_W     = 3 * FIELD_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_SEL,
        ST_SEL_END,
        ST_R_RD,
        ST_R_CHK,
        ST_R_UPD,
        ST_FIN,
        ST_DONE
    } t_state;

endpackage

### src/rtsp_ram.sv
`timescale 1ns / 1ps

module rtsp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### src/round_trip_shortest_path_max.sv
`timescale 1ns / 1ps

// Round-trip shortest-path maximum over a stored directed graph.
//
// Command channel: an item transfers on a rising edge with start high and
// busy low. A load item (op 0) appends one edge to the edge memory, or sets
// the overflow flag when it is full; busy stays low, so loads may follow back
// to back. A clear item (op 2) empties the edge memory and drops the overflow
// flag. Op 3 is ignored. A compute item (op 1) raises busy and runs two
// shortest-path searches, from the target and towards it, then a final scan
// over nodes; with node count 0 or a target not below it, it goes straight to
// the result. Each search has one clearing pass over the nodes, then per
// settled node one selection scan over the nodes plus a relaxation sweep over
// the edges, and a last selection scan that finds no open node. The node and
// edge memories give one read per cycle each.
// The result shows for exactly one cycle with o_done high; the receiver
// cannot stall it. Busy falls in the cycle after.
// Configuration writes (node count, target) land on any edge with
// i_cfg_we high and must only come while idle. Reset empties the edge
// memory, clears the overflow flag and restores node count 1024, target 0.
module round_trip_shortest_path_max #(
    parameter int MAX_NODES = rtsp_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = rtsp_pkg::MAX_EDGES_DEF,
    parameter int DIST_BITS = rtsp_pkg::DIST_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rtsp_pkg::OP_W-1:0]       i_op,
    input  logic [rtsp_pkg::FIELD_W-1:0]    i_edge_from,
    input  logic [rtsp_pkg::FIELD_W-1:0]    i_edge_to,
    input  logic [rtsp_pkg::FIELD_W-1:0]    i_edge_weight,
    input  logic                            i_cfg_we,
    input  logic [rtsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rtsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_done,
    output logic [rtsp_pkg::OUT_W-1:0]      o_max_round_trip,
    output logic                            o_unreachable,
    output logic                            o_edge_overflow
);

    localparam int FW   = rtsp_pkg::FIELD_W;
    localparam int NB   = $clog2(MAX_NODES);
    localparam int NCW  = NB + 1;
    localparam int CW   = ((NB > FW) ? NB : FW) + 1;
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int DW   = DIST_BITS;
    localparam int NW   = DW + 2;
    localparam int SW   = ((DW + 1) > (rtsp_pkg::OUT_W + 1)) ? (DW + 1) : (rtsp_pkg::OUT_W + 1);
    localparam int OW   = rtsp_pkg::OUT_W;
    localparam logic [DW:0]   DIST_MAX = {1'b0, {DW{1'b1}}};
    localparam logic [SW-1:0] SUM_CAP  = (DW < OW) ? SW'({DW{1'b1}}) : SW'({OW{1'b1}});

    rtsp_pkg::t_state r_state, n_state;

    // configuration
    logic [rtsp_pkg::NC_W-1:0] r_node_count;
    logic [FW-1:0]             r_target;

    // edge store bookkeeping
    logic [ECW-1:0] r_cnt;
    logic           r_ovf;

    // search control and datapath
    logic           r_dir;       // 0: from target along edges, 1: against
    logic [NCW-1:0] r_n;
    logic [NB-1:0]  r_tgt;
    logic [NCW-1:0] r_idx;
    logic           r_pend;
    logic [NB-1:0]  r_pidx;
    logic           r_found;
    logic [NB-1:0]  r_u;
    logic [DW-1:0]  r_ud;
    logic [ECW-1:0] r_e;
    logic [NB-1:0]  r_b;
    logic [FW-1:0]  r_w;
    logic [OW-1:0]  r_best;
    logic           r_lost;

    // memories
    logic                         w_edge_we;
    logic [rtsp_pkg::EDGE_W-1:0]  w_edge_q;
    logic [NB-1:0]                w_node_raddr;
    logic                         w_node_we;
    logic [NB-1:0]                w_node_waddr;
    logic [NW-1:0]                w_node_wdata;
    logic [NW-1:0]                w_from_q, w_to_q, w_q;

    logic           w_accept;
    logic [NCW-1:0] w_n;
    logic [FW-1:0]  w_a, w_bf;
    logic           w_match;
    logic [DW:0]    w_nd_raw;
    logic [DW-1:0]  w_nd;
    logic           w_better;
    logic [SW-1:0]  w_sum_raw, w_sum;
    logic [DW-1:0]  w_qd;

    assign w_accept = start && !busy;
    assign busy     = (r_state != rtsp_pkg::ST_IDLE);

    // clamp the node count to the storage size
    assign w_n = (int'(r_node_count) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(r_node_count);

    // edge word: from, to, weight; swap the endpoints for the backward search
    assign w_a  = r_dir ? w_edge_q[2*FW-1:FW]   : w_edge_q[3*FW-1:2*FW];
    assign w_bf = r_dir ? w_edge_q[3*FW-1:2*FW] : w_edge_q[2*FW-1:FW];
    assign w_match = (CW'(w_a) == CW'(r_u)) && (CW'(w_bf) < CW'(r_n));

    assign w_q      = r_dir ? w_to_q : w_from_q;
    assign w_qd     = w_q[DW-1:0];
    assign w_nd_raw = {1'b0, r_ud} + (DW + 1)'(r_w);
    assign w_nd     = (w_nd_raw > DIST_MAX) ? DIST_MAX[DW-1:0] : w_nd_raw[DW-1:0];
    assign w_better = !w_q[NW-1] || (w_nd < w_qd);

    assign w_sum_raw = SW'(w_from_q[DW-1:0]) + SW'(w_to_q[DW-1:0]);
    assign w_sum     = (w_sum_raw > SUM_CAP) ? SUM_CAP : w_sum_raw;

    assign w_edge_we = w_accept && (i_op == rtsp_pkg::OP_LOAD) && (int'(r_cnt) < MAX_EDGES);

    rtsp_ram #(
        .WIDTH (rtsp_pkg::EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (r_cnt[EAW-1:0]),
        .i_wdata ({i_edge_from, i_edge_to, i_edge_weight}),
        .i_raddr (r_e[EAW-1:0]),
        .o_rdata (w_edge_q)
    );

    rtsp_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_NODES)
    ) u_from_ram (
        .i_clk   (i_clk),
        .i_we    (w_node_we && !r_dir),
        .i_waddr (w_node_waddr),
        .i_wdata (w_node_wdata),
        .i_raddr (w_node_raddr),
        .o_rdata (w_from_q)
    );

    rtsp_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_NODES)
    ) u_to_ram (
        .i_clk   (i_clk),
        .i_we    (w_node_we && r_dir),
        .i_waddr (w_node_waddr),
        .i_wdata (w_node_wdata),
        .i_raddr (w_node_raddr),
        .o_rdata (w_to_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rtsp_pkg::ST_IDLE: begin
                if (w_accept && (i_op == rtsp_pkg::OP_COMPUTE)) begin
                    if ((w_n == '0) || (int'(r_target) >= int'(w_n))) begin
                        n_state = rtsp_pkg::ST_DONE;
                    end else begin
                        n_state = rtsp_pkg::ST_CLR;
                    end
                end
            end
            rtsp_pkg::ST_CLR: begin
                if (r_idx == r_n) begin
                    n_state = rtsp_pkg::ST_SEL;
                end
            end
            rtsp_pkg::ST_SEL: begin
                if (r_idx == r_n) begin
                    n_state = rtsp_pkg::ST_SEL_END;
                end
            end
            rtsp_pkg::ST_SEL_END: begin
                if (r_found) begin
                    n_state = rtsp_pkg::ST_R_RD;
                end else if (!r_dir) begin
                    n_state = rtsp_pkg::ST_CLR;
                end else begin
                    n_state = rtsp_pkg::ST_FIN;
                end
            end
            rtsp_pkg::ST_R_RD: begin
                if (r_e < r_cnt) begin
                    n_state = rtsp_pkg::ST_R_CHK;
                end else begin
                    n_state = rtsp_pkg::ST_SEL;
                end
            end
            rtsp_pkg::ST_R_CHK: begin
                n_state = w_match ? rtsp_pkg::ST_R_UPD : rtsp_pkg::ST_R_RD;
            end
            rtsp_pkg::ST_R_UPD: begin
                n_state = rtsp_pkg::ST_R_RD;
            end
            rtsp_pkg::ST_FIN: begin
                if (r_idx == r_n && !r_pend) begin
                    n_state = rtsp_pkg::ST_DONE;
                end
            end
            rtsp_pkg::ST_DONE: begin
                n_state = rtsp_pkg::ST_IDLE;
            end
            default: begin
                n_state = rtsp_pkg::ST_IDLE;
            end
        endcase
    end

    // memory ports and result strobe
    always_comb begin
        w_node_raddr = r_idx[NB-1:0];
        w_node_we    = 1'b0;
        w_node_waddr = r_idx[NB-1:0];
        w_node_wdata = '0;
        o_done       = 1'b0;
        case (r_state)
            rtsp_pkg::ST_CLR: begin
                w_node_we = 1'b1;
                if (r_idx == r_n) begin
                    // seed the target: reached, distance zero
                    w_node_waddr = r_tgt;
                    w_node_wdata = {1'b1, 1'b0, {DW{1'b0}}};
                end
            end
            rtsp_pkg::ST_SEL_END: begin
                if (r_found) begin
                    w_node_we    = 1'b1;
                    w_node_waddr = r_u;
                    w_node_wdata = {1'b1, 1'b1, r_ud};
                end
            end
            rtsp_pkg::ST_R_CHK: begin
                w_node_raddr = NB'(w_bf);
            end
            rtsp_pkg::ST_R_UPD: begin
                if (w_better) begin
                    w_node_we    = 1'b1;
                    w_node_waddr = r_b;
                    w_node_wdata = {1'b1, w_q[NW-2], w_nd};
                end
            end
            rtsp_pkg::ST_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                w_node_we = 1'b0;
            end
        endcase
    end

    assign o_max_round_trip = r_best;
    assign o_unreachable    = r_lost;
    assign o_edge_overflow  = r_ovf;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rtsp_pkg::ST_IDLE;
            r_node_count <= rtsp_pkg::NC_W'(1024);
            r_target     <= '0;
            r_cnt        <= '0;
            r_ovf        <= 1'b0;
            r_dir        <= 1'b0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rtsp_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    rtsp_pkg::CFG_TARGET:     r_target     <= i_cfg_data[FW-1:0];
                    default:                  r_target     <= r_target;
                endcase
            end
            if (w_accept) begin
                case (i_op)
                    rtsp_pkg::OP_LOAD: begin
                        if (w_edge_we) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    rtsp_pkg::OP_CLEAR: begin
                        r_cnt <= '0;
                        r_ovf <= 1'b0;
                    end
                    rtsp_pkg::OP_COMPUTE: begin
                        r_dir <= 1'b0;
                    end
                    default: begin
                        r_dir <= r_dir;
                    end
                endcase
            end
            case (r_state)
                rtsp_pkg::ST_CLR: begin
                    if (r_idx == r_n) begin
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                    end
                end
                rtsp_pkg::ST_SEL: begin
                    r_pend <= (r_idx < r_n);
                    // keep the first strictly smallest open node
                    if (r_pend && w_q[NW-1] && !w_q[NW-2] && (!r_found || w_qd < r_ud)) begin
                        r_found <= 1'b1;
                    end
                end
                rtsp_pkg::ST_SEL_END: begin
                    r_pend <= 1'b0;
                    if (!r_found) begin
                        r_dir <= 1'b1;
                    end
                end
                rtsp_pkg::ST_R_RD: begin
                    if (!(r_e < r_cnt)) begin
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                    end
                end
                rtsp_pkg::ST_FIN: begin
                    r_pend <= (r_idx < r_n);
                end
                default: begin
                    r_pend <= r_pend;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            rtsp_pkg::ST_IDLE: begin
                r_n    <= w_n;
                r_tgt  <= NB'(r_target);
                r_idx  <= '0;
                r_best <= '0;
                r_lost <= (w_n != '0);
            end
            rtsp_pkg::ST_CLR: begin
                r_idx <= (r_idx == r_n) ? '0 : r_idx + 1'b1;
                if (r_idx == r_n) begin
                    r_lost <= 1'b0;
                end
            end
            rtsp_pkg::ST_SEL: begin
                r_pidx <= r_idx[NB-1:0];
                if (r_idx < r_n) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_pend && w_q[NW-1] && !w_q[NW-2] && (!r_found || w_qd < r_ud)) begin
                    r_u  <= r_pidx;
                    r_ud <= w_qd;
                end
            end
            rtsp_pkg::ST_SEL_END: begin
                r_e   <= '0;
                r_idx <= '0;
            end
            rtsp_pkg::ST_R_RD: begin
                r_idx <= '0;
            end
            rtsp_pkg::ST_R_CHK: begin
                r_b <= NB'(w_bf);
                r_w <= w_edge_q[FW-1:0];
                if (!w_match) begin
                    r_e <= r_e + 1'b1;
                end
            end
            rtsp_pkg::ST_R_UPD: begin
                r_e <= r_e + 1'b1;
            end
            rtsp_pkg::ST_FIN: begin
                if (r_idx < r_n) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_pend) begin
                    if (!(w_from_q[NW-1] && w_to_q[NW-1])) begin
                        r_lost <= 1'b1;
                    end else if (w_sum > SW'(r_best)) begin
                        r_best <= w_sum[OW-1:0];
                    end
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    // A local shortest-path predictor follows every transfer on the command
    // channel and on the configuration port. Each compute transfer queues one
    // expected answer, and the answer checker compares each o_done strobe with
    // the oldest one. Named tests run in turn: reset defaults, a small cycle
    // graph, extreme node numbers and weights, node count and target corners,
    // clearing, then random graph sessions.

    localparam int N_MAX      = rtsp_pkg::MAX_NODES_DEF;
    localparam int E_MAX      = rtsp_pkg::MAX_EDGES_DEF;
    localparam int DIST_SAT   = (1 << rtsp_pkg::DIST_BITS_DEF) - 1;
    localparam int SUM_SAT    = 24'hFFFFFF;
    localparam int STALL_MAX  = 20000000;
    localparam int SETTLE_CYC = 6;
    localparam int RAND_ITEMS = 1100;
    localparam int FW         = rtsp_pkg::FIELD_W;

    typedef struct packed {
        logic [rtsp_pkg::OUT_W-1:0] max_round_trip;
        logic                       unreachable;
        logic                       edge_overflow;
    } t_answer;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [rtsp_pkg::OP_W-1:0]       i_op;
    logic [FW-1:0]                   i_edge_from;
    logic [FW-1:0]                   i_edge_to;
    logic [FW-1:0]                   i_edge_weight;
    logic                            i_cfg_we;
    logic [rtsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rtsp_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            o_done;
    logic [rtsp_pkg::OUT_W-1:0]      o_max_round_trip;
    logic                            o_unreachable;
    logic                            o_edge_overflow;

    round_trip_shortest_path_max dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_edge_from      (i_edge_from),
        .i_edge_to        (i_edge_to),
        .i_edge_weight    (i_edge_weight),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_max_round_trip (o_max_round_trip),
        .o_unreachable    (o_unreachable),
        .o_edge_overflow  (o_edge_overflow)
    );

    // Predictor state: its own copy of the edge memory and the registers
    logic [rtsp_pkg::EDGE_W-1:0] graph_edges[$];
    logic                        overflow_flag;
    int unsigned                 cfg_nodes;
    int unsigned                 cfg_target;
    int unsigned                 sdist[N_MAX];
    bit                          sreach[N_MAX];
    bit                          settled[N_MAX];
    int unsigned                 dist_out[N_MAX];
    bit                          reach_out[N_MAX];

    t_answer     pending_answers[$];
    int          fail_count;
    int          items_sent;
    int          burst_left;
    int unsigned stall_cycles;

    // Clock: 20 ns period
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // One Dijkstra search from src; backward walks the edges against their
    // direction. Leaves distances in sdist and reach marks in sreach.
    function automatic void walk_graph(bit backward, int unsigned n, int unsigned src);
        int unsigned u, a, b, nd;
        for (int i = 0; i < n; i++) begin
            sdist[i]   = 0;
            sreach[i]  = 1'b0;
            settled[i] = 1'b0;
        end
        sreach[src] = 1'b1;
        forever begin
            u = n;
            for (int i = 0; i < n; i++) begin
                if (sreach[i] && !settled[i] && (u == n || sdist[i] < sdist[u]))
                    u = i;
            end
            if (u == n)
                break;
            settled[u] = 1'b1;
            foreach (graph_edges[e]) begin
                a = graph_edges[e][29:20];
                b = graph_edges[e][19:10];
                if (backward) begin
                    a = graph_edges[e][19:10];
                    b = graph_edges[e][29:20];
                end
                if (a != u || b >= n)
                    continue;
                nd = sdist[u] + graph_edges[e][9:0];
                if (nd > DIST_SAT)
                    nd = DIST_SAT;
                if (!sreach[b] || nd < sdist[b]) begin
                    sreach[b] = 1'b1;
                    sdist[b]  = nd;
                end
            end
        end
    endfunction

    function automatic t_answer predict_round_trip();
        t_answer     ans;
        int unsigned n, sum, best;
        bit          lost;
        best = 0;
        lost = 1'b0;
        n = (cfg_nodes > N_MAX) ? N_MAX : cfg_nodes;
        if (n > 0 && cfg_target >= n) begin
            lost = 1'b1;
        end else if (n > 0) begin
            walk_graph(1'b0, n, cfg_target);
            for (int i = 0; i < n; i++) begin
                dist_out[i]  = sdist[i];
                reach_out[i] = sreach[i];
            end
            walk_graph(1'b1, n, cfg_target);
            for (int i = 0; i < n; i++) begin
                if (!reach_out[i] || !sreach[i]) begin
                    lost = 1'b1;
                    continue;
                end
                sum = dist_out[i] + sdist[i];
                if (sum > SUM_SAT)
                    sum = SUM_SAT;
                if (sum > best)
                    best = sum;
            end
        end
        ans.max_round_trip = best[rtsp_pkg::OUT_W-1:0];
        ans.unreachable    = lost;
        ans.edge_overflow  = overflow_flag;
        return ans;
    endfunction

    // Apply one accepted command to the predictor
    function automatic void track_command(rtsp_pkg::t_op op, logic [FW-1:0] from_n,
                                          logic [FW-1:0] to_n,
                                          logic [FW-1:0] weight);
        case (op)
            rtsp_pkg::OP_LOAD: begin
                if (graph_edges.size() < E_MAX)
                    graph_edges.insert(graph_edges.size(), {from_n, to_n, weight});
                else
                    overflow_flag = 1'b1;
            end
            rtsp_pkg::OP_CLEAR: begin
                graph_edges.delete();
                overflow_flag = 1'b0;
            end
            rtsp_pkg::OP_COMPUTE: begin
                pending_answers.insert(pending_answers.size(), predict_round_trip());
            end
            default: ;
        endcase
    endfunction

    // Send one command: hold start until the transfer, then track it.
    // Called just after a rising edge; leaves start high for a following
    // transfer, and drops it only for a gap between bursts.
    task automatic send_cmd(rtsp_pkg::t_op op, int unsigned from_n = 0,
                            int unsigned to_n = 0, int unsigned weight = 0);
        logic [FW-1:0] f_from, f_to, f_weight;
        f_from   = from_n[FW-1:0];
        f_to     = to_n[FW-1:0];
        f_weight = weight[FW-1:0];
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        start         <= 1'b1;
        i_op          <= op;
        i_edge_from   <= f_from;
        i_edge_to     <= f_to;
        i_edge_weight <= f_weight;
        do @(posedge i_clk); while (busy);
        track_command(op, f_from, f_to, f_weight);
        items_sent++;
    endtask

    // Drop start and wait until every answer is in and the block is idle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [rtsp_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[rtsp_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rtsp_pkg::CFG_NODE_COUNT)
            cfg_nodes = value & 11'h7FF;
        else
            cfg_target = value & 10'h3FF;
    endtask

    task automatic set_graph(int unsigned nodes, int unsigned target);
        wait_idle();
        write_cfg(rtsp_pkg::CFG_NODE_COUNT, nodes);
        write_cfg(rtsp_pkg::CFG_TARGET, target);
    endtask

    // Answer checker: compare each strobed answer with the oldest expectation
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_done) begin
            if (pending_answers.size() == 0) begin
                $error("answer with none expected: max_round_trip %0d", o_max_round_trip);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_max_round_trip !== want.max_round_trip) begin
                    $error("max_round_trip expected %0d actual %0d",
                           want.max_round_trip, o_max_round_trip);
                    fail_count++;
                end
                if (o_unreachable !== want.unreachable) begin
                    $error("unreachable expected %0b actual %0b",
                           want.unreachable, o_unreachable);
                    fail_count++;
                end
                if (o_edge_overflow !== want.edge_overflow) begin
                    $error("edge_overflow expected %0b actual %0b",
                           want.edge_overflow, o_edge_overflow);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing transfers
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Compute straight after reset: only the target itself is reached
    task automatic test_reset_defaults();
        send_cmd(rtsp_pkg::OP_COMPUTE);
    endtask

    // Three-node ring with a parallel edge, a self-loop, a zero weight and
    // an unused op code that must leave the graph alone
    task automatic test_small_ring();
        set_graph(3, 0);
        send_cmd(rtsp_pkg::OP_LOAD, 0, 1, 5);
        send_cmd(rtsp_pkg::OP_LOAD, 1, 2, 7);
        send_cmd(rtsp_pkg::OP_LOAD, 2, 0, 1023);
        send_cmd(rtsp_pkg::OP_LOAD, 2, 0, 0);
        send_cmd(rtsp_pkg::OP_LOAD, 1, 1, 3);
        send_cmd(rtsp_pkg::OP_NONE, 1023, 1023, 1023);
        send_cmd(rtsp_pkg::OP_COMPUTE);
    endtask

    // Highest node numbers and weights, and an endpoint outside the nodes
    task automatic test_field_extremes();
        set_graph(1024, 1023);
        send_cmd(rtsp_pkg::OP_CLEAR);
        send_cmd(rtsp_pkg::OP_LOAD, 1023, 0, 1023);
        send_cmd(rtsp_pkg::OP_LOAD, 0, 1023, 0);
        send_cmd(rtsp_pkg::OP_COMPUTE);
        set_graph(2, 1);
        send_cmd(rtsp_pkg::OP_LOAD, 1, 1023, 1);
        send_cmd(rtsp_pkg::OP_COMPUTE);
    endtask

    // No nodes, one node, target out of range, node count above the maximum
    task automatic test_count_corners();
        set_graph(0, 0);
        send_cmd(rtsp_pkg::OP_COMPUTE);
        set_graph(1, 0);
        send_cmd(rtsp_pkg::OP_COMPUTE);
        set_graph(2, 1023);
        send_cmd(rtsp_pkg::OP_COMPUTE);
        set_graph(2047, 0);
        send_cmd(rtsp_pkg::OP_COMPUTE);
    endtask

    task automatic test_clear();
        set_graph(2, 0);
        send_cmd(rtsp_pkg::OP_LOAD, 0, 1, 9);
        send_cmd(rtsp_pkg::OP_LOAD, 1, 0, 4);
        send_cmd(rtsp_pkg::OP_CLEAR);
        send_cmd(rtsp_pkg::OP_COMPUTE);
    endtask

    // Random sessions: fresh settings, mostly a clean graph of small size
    // with random edges, some noise, then one or more computes
    task automatic test_random_graphs();
        int unsigned nodes, target, span;
        int          start_count;
        start_count = items_sent;
        while (items_sent - start_count < RAND_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       nodes = 0;
                1:       nodes = 1024;
                2:       nodes = $urandom_range(1025, 2047);
                default: nodes = $urandom_range(1, 12);
            endcase
            span = (nodes == 0) ? 1 : ((nodes > N_MAX) ? N_MAX : nodes);
            target = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, span - 1);
            set_graph(nodes, target);
            if ($urandom_range(0, 4) != 0)
                send_cmd(rtsp_pkg::OP_CLEAR);
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(3, 25)) begin
                    case ($urandom_range(0, 15))
                        0:       send_cmd(rtsp_pkg::OP_LOAD, $urandom, $urandom, $urandom);
                        1:       send_cmd(rtsp_pkg::OP_NONE, $urandom, $urandom, $urandom);
                        default: send_cmd(rtsp_pkg::OP_LOAD,
                                          $urandom_range(0, (span > 12 ? 12 : span) - 1),
                                          $urandom_range(0, (span > 12 ? 12 : span) - 1),
                                          $urandom_range(0, 1023));
                    endcase
                end
                send_cmd(rtsp_pkg::OP_COMPUTE);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = rtsp_pkg::OP_NONE;
        i_edge_from   = '0;
        i_edge_to     = '0;
        i_edge_weight = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = rtsp_pkg::CFG_NODE_COUNT;
        i_cfg_data    = '0;
        overflow_flag = 1'b0;
        cfg_nodes     = 1024;
        cfg_target    = 0;
        fail_count    = 0;
        items_sent    = 0;
        burst_left    = 0;
        stall_cycles  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_small_ring();
        test_field_extremes();
        test_count_corners();
        test_clear();
        test_random_graphs();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
src/rtsp_pkg.sv
src/rtsp_ram.sv
src/round_trip_shortest_path_max.sv
verif/tb_top.sv
